[rtl/hsfr_pkg.sv]
// shared types, constants and codes of the byte-stuffed frame receiver
`timescale 1ns / 1ps

package hsfr_pkg;

  // frame length bound, in line bytes; a frame longer than MAX_FRAME - 2 bytes is rejected
  localparam int MAX_FRAME = 4096;
  localparam int CNT_W     = $clog2(MAX_FRAME);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAME - 2);

  // line bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_TO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_FROM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_SET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_DISC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_UA   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_I0   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_I1   = 3'd6;

  // receive phase
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_IDLE = 3'd1,
    PH_ADDR = 3'd2,
    PH_CTRL = 3'd3,
    PH_DATA = 3'd4,
    PH_BAD  = 3'd5
  } phase_t;

  // verdict codes
  typedef enum logic [2:0] {
    RESP_NONE   = 3'd0,
    RESP_UA     = 3'd1,
    RESP_RR     = 3'd2,
    RESP_REJ    = 3'd3,
    RESP_DISC   = 3'd4,
    RESP_CLOSED = 3'd5
  } resp_t;

  // configuration registers
  typedef struct packed {
    logic [7:0] addr_to;
    logic [7:0] addr_from;
    logic [7:0] ctrl_set;
    logic [7:0] ctrl_disc;
    logic [7:0] ctrl_ua;
    logic [7:0] ctrl_i0;
    logic [7:0] ctrl_i1;
  } cfg_t;

  // receiver state
  typedef struct packed {
    phase_t           phase;
    logic             esc;
    logic [7:0]       addr;
    logic [7:0]       ctrl;
    logic [7:0]       dxor;
    logic [7:0]       held;
    logic             held_v;
    logic [CNT_W-1:0] cnt;
    logic             exp_seq;
    logic             link_open;
  } state_t;

  // one result transaction
  typedef struct packed {
    logic       emit;
    logic       kind;
    logic [7:0] payload;
    resp_t      resp;
    logic       ack_seq;
    logic       last;
  } result_t;

endpackage

[rtl/hsfr_cfg.sv]
// configuration register file of the frame receiver
`timescale 1ns / 1ps

module hsfr_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [hsfr_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [7:0]                      wr_data,
  output hsfr_pkg::cfg_t                  cfg
);
  import hsfr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode the register index
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_ADDR_TO:   cfg_nxt.addr_to   = wr_data;
        CFG_ADDR_FROM: cfg_nxt.addr_from = wr_data;
        CFG_CTRL_SET:  cfg_nxt.ctrl_set  = wr_data;
        CFG_CTRL_DISC: cfg_nxt.ctrl_disc = wr_data;
        CFG_CTRL_UA:   cfg_nxt.ctrl_ua   = wr_data;
        CFG_CTRL_I0:   cfg_nxt.ctrl_i0   = wr_data;
        CFG_CTRL_I1:   cfg_nxt.ctrl_i1   = wr_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  // registers with their reset codes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.addr_to   <= 8'd3;
      cfg_r.addr_from <= 8'd1;
      cfg_r.ctrl_set  <= 8'd3;
      cfg_r.ctrl_disc <= 8'd11;
      cfg_r.ctrl_ua   <= 8'd7;
      cfg_r.ctrl_i0   <= 8'd0;
      cfg_r.ctrl_i1   <= 8'd64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/hsfr_decode.sv]
// per-byte next-state and result logic of the frame receiver
`timescale 1ns / 1ps

module hsfr_decode (
  input  hsfr_pkg::cfg_t    cfg,
  input  hsfr_pkg::state_t  st,
  input  logic [7:0]        rx_byte,
  output hsfr_pkg::state_t  st_nxt,
  output hsfr_pkg::result_t res
);
  import hsfr_pkg::*;

  // drop all per-frame state, keep the link state
  function automatic state_t clear_frame(state_t s, phase_t ph);
    state_t c;
    c           = s;
    c.phase     = ph;
    c.esc       = 1'b0;
    c.addr      = 8'd0;
    c.ctrl      = 8'd0;
    c.dxor      = 8'd0;
    c.held      = 8'd0;
    c.held_v    = 1'b0;
    c.cnt       = '0;
    return c;
  endfunction

  logic   to_me;
  logic   is_info;
  logic   seq;
  logic   super_ok;
  logic   check_ok;
  resp_t  verdict;
  logic   toggle;
  logic   open_set;
  logic   open_clr;
  logic   take;
  logic [7:0] b;
  logic   phase_ok;

  // closing-flag verdict
  always_comb begin
    to_me    = (st.addr == cfg.addr_to);
    is_info  = to_me && ((st.ctrl == cfg.ctrl_i0) || (st.ctrl == cfg.ctrl_i1));
    seq      = (st.ctrl == cfg.ctrl_i0) ? 1'b0 : 1'b1;
    super_ok = !st.held_v && !st.esc;
    check_ok = st.link_open && st.held_v && !st.esc && (st.dxor == st.held) &&
               (seq == st.exp_seq);
    toggle   = 1'b0;
    open_set = 1'b0;
    open_clr = 1'b0;
    priority if (st.phase != PH_DATA) begin
      verdict = RESP_REJ;
    end else if (super_ok && to_me && (st.ctrl == cfg.ctrl_set)) begin
      verdict  = RESP_UA;
      open_set = 1'b1;
    end else if (super_ok && to_me && (st.ctrl == cfg.ctrl_disc)) begin
      verdict = RESP_DISC;
    end else if (super_ok && (st.addr == cfg.addr_from) && (st.ctrl == cfg.ctrl_ua)) begin
      verdict  = RESP_CLOSED;
      open_clr = 1'b1;
    end else if (is_info && check_ok) begin
      verdict = RESP_RR;
      toggle  = 1'b1;
    end else if (is_info) begin
      verdict = RESP_REJ;
    end else begin
      verdict = RESP_NONE;
    end
  end

  // unstuffing of the current byte
  always_comb begin
    if (st.esc) begin
      b    = rx_byte ^ ESC_XOR;
      take = 1'b1;
    end else if (rx_byte == ESC_BYTE) begin
      b    = rx_byte;
      take = 1'b0;
    end else begin
      b    = rx_byte;
      take = 1'b1;
    end
  end

  assign phase_ok = (st.phase <= PH_BAD);

  // state update and result
  always_comb begin
    st_nxt      = st;
    res         = '0;
    res.resp    = RESP_NONE;
    if (st.phase == PH_HUNT) begin
      if (rx_byte == FLAG_BYTE) begin
        st_nxt = clear_frame(st, PH_IDLE);
      end
    end else if (!phase_ok) begin
      st_nxt = clear_frame(st, PH_HUNT);
    end else if (rx_byte == FLAG_BYTE) begin
      // repeated flags are skipped while no frame byte has arrived
      if (!(st.phase == PH_IDLE && !st.esc)) begin
        st_nxt = clear_frame(st, PH_IDLE);
        if (open_set) begin
          st_nxt.link_open = 1'b1;
          st_nxt.exp_seq   = 1'b0;
        end else if (open_clr) begin
          st_nxt.link_open = 1'b0;
        end else if (toggle) begin
          st_nxt.exp_seq = ~st.exp_seq;
        end
        res.emit = 1'b1;
        res.kind = 1'b1;
        res.resp = verdict;
        res.last = 1'b1;
        res.ack_seq = ((verdict == RESP_RR) || (verdict == RESP_REJ)) ?
                      st_nxt.exp_seq : 1'b0;
      end
    end else if (st.cnt >= CNT_LIMIT) begin
      // overlong frame
      st_nxt      = clear_frame(st, PH_HUNT);
      res.emit    = 1'b1;
      res.kind    = 1'b1;
      res.resp    = RESP_REJ;
      res.ack_seq = st.exp_seq;
      res.last    = 1'b1;
    end else begin
      st_nxt.cnt = st.cnt + 1'b1;
      st_nxt.esc = !take;
      if (take) begin
        unique case (st.phase)
          PH_IDLE: begin
            st_nxt.addr  = b;
            st_nxt.phase = PH_ADDR;
          end
          PH_ADDR: begin
            st_nxt.ctrl  = b;
            st_nxt.phase = PH_CTRL;
          end
          PH_CTRL: begin
            st_nxt.phase = (b == (st.addr ^ st.ctrl)) ? PH_DATA : PH_BAD;
          end
          default: begin
            // held byte goes out once a later data byte shows it is not the check
            if (st.held_v) begin
              st_nxt.dxor = st.dxor ^ st.held;
              res.emit    = 1'b1;
              res.payload = st.held;
            end
            st_nxt.held   = b;
            st_nxt.held_v = 1'b1;
          end
        endcase
      end
    end
  end

endmodule

[rtl/hdlc_style_frame_receiver_core.sv]
// top level of the byte-stuffed frame receiver with stop-and-wait verdicts
`timescale 1ns / 1ps

// channel  | direction | handshake              | payload
// in_      | input     | in_valid / in_ready    | in_rx_byte
// out_     | output    | out_valid / out_ready  | out_kind, out_payload_byte, out_response,
//          |           |                        | out_ack_seq, out_frame_last
// cfg_     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one line byte per cycle while in_ready is high; a byte is decoded in the cycle it is taken and its
// result sits in the output register the next cycle
// in_ready is high while the output register is empty or being emptied
// synchronous active-low reset; configuration writes are always taken
module hdlc_style_frame_receiver_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_kind,
  output logic [7:0]                     out_payload_byte,
  output logic [2:0]                     out_response,
  output logic                           out_ack_seq,
  output logic                           out_frame_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hsfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import hsfr_pkg::*;

  cfg_t    cfg;
  state_t  st_r;
  state_t  st_nxt;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    in_acc;

  assign cfg_ready = 1'b1;

  hsfr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  hsfr_decode u_decode (
    .cfg     (cfg),
    .st      (st_r),
    .rx_byte (in_rx_byte),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // receiver state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase     <= PH_HUNT;
      st_r.esc       <= 1'b0;
      st_r.addr      <= 8'd0;
      st_r.ctrl      <= 8'd0;
      st_r.dxor      <= 8'd0;
      st_r.held      <= 8'd0;
      st_r.held_v    <= 1'b0;
      st_r.cnt       <= '0;
      st_r.exp_seq   <= 1'b0;
      st_r.link_open <= 1'b0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res.emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res.emit) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = res_r.kind;
  assign out_payload_byte = res_r.payload;
  assign out_response     = res_r.resp;
  assign out_ack_seq      = res_r.ack_seq;
  assign out_frame_last   = res_r.last;

endmodule

[tb/hdlc_style_frame_receiver_core_tb.sv]
// self-checking testbench of the byte-stuffed frame receiver core
`timescale 1ns / 1ps

module hdlc_style_frame_receiver_core_tb;
  import hsfr_pkg::*;

  // one expected result transaction
  typedef struct {
    logic       kind;
    logic [7:0] payload;
    resp_t      resp;
    logic       ack_seq;
    logic       last;
  } rx_result_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready  = 1'b1;
  logic                 out_kind;
  logic [7:0]           out_payload_byte;
  logic [2:0]           out_response;
  logic                 out_ack_seq;
  logic                 out_frame_last;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_ADDR_TO;
  logic [7:0]           cfg_data   = 8'h00;

  hdlc_style_frame_receiver_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_response     (out_response),
    .out_ack_seq      (out_ack_seq),
    .out_frame_last   (out_frame_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // line bytes waiting to be sent and results still owed by the block
  logic [7:0] line_bytes[$];
  rx_result_t awaited_results[$];
  int         bytes_queued     = 0;
  int         bytes_taken      = 0;
  int         mismatches       = 0;
  int         send_gap         = 0;
  int         ready_hold       = 0;
  int         long_holds_asked = 0;
  int         long_holds_done  = 0;
  bit         tail_quiet       = 1'b0;
  logic       gen_seq          = 1'b0;
  cfg_t       link_cfg;

  // receiver model state
  phase_t     rx_phase;
  logic       rx_esc;
  logic [7:0] rx_addr;
  logic [7:0] rx_ctrl;
  logic [7:0] rx_xor;
  logic [7:0] rx_held;
  logic       rx_held_v;
  int         rx_count;
  logic       rx_exp_seq;
  logic       rx_link_open;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // drop everything of the frame in progress
  function automatic void clear_frame_state(phase_t next_phase);
    rx_phase  = next_phase;
    rx_esc    = 1'b0;
    rx_addr   = 8'h00;
    rx_ctrl   = 8'h00;
    rx_xor    = 8'h00;
    rx_held   = 8'h00;
    rx_held_v = 1'b0;
    rx_count  = 0;
  endfunction

  function automatic void await_result(logic kind, logic [7:0] payload, resp_t resp);
    rx_result_t r;
    r.kind    = kind;
    r.payload = payload;
    r.resp    = resp;
    r.ack_seq = (resp == RESP_RR || resp == RESP_REJ) ? rx_exp_seq : 1'b0;
    r.last    = kind;
    awaited_results.push_back(r);
  endfunction

  // verdict at the closing flag, updating link and sequence state
  function automatic resp_t judge_frame();
    logic seq;
    if (rx_phase != PH_DATA) return RESP_REJ;
    if (!rx_held_v && !rx_esc) begin
      if (rx_addr == link_cfg.addr_to && rx_ctrl == link_cfg.ctrl_set) begin
        rx_link_open = 1'b1;
        rx_exp_seq   = 1'b0;
        return RESP_UA;
      end
      if (rx_addr == link_cfg.addr_to && rx_ctrl == link_cfg.ctrl_disc) return RESP_DISC;
      if (rx_addr == link_cfg.addr_from && rx_ctrl == link_cfg.ctrl_ua) begin
        rx_link_open = 1'b0;
        return RESP_CLOSED;
      end
    end
    if (rx_addr == link_cfg.addr_to &&
        (rx_ctrl == link_cfg.ctrl_i0 || rx_ctrl == link_cfg.ctrl_i1)) begin
      seq = (rx_ctrl != link_cfg.ctrl_i0);
      if (rx_link_open && rx_held_v && !rx_esc && rx_xor == rx_held && seq == rx_exp_seq) begin
        rx_exp_seq = ~rx_exp_seq;
        return RESP_RR;
      end
      return RESP_REJ;
    end
    return RESP_NONE;
  endfunction

  // one accepted line byte through the receiver model
  function automatic void decode_line_byte(logic [7:0] raw);
    logic [7:0] b;
    if (rx_phase == PH_HUNT) begin
      if (raw == FLAG_BYTE) clear_frame_state(PH_IDLE);
      return;
    end
    if (raw == FLAG_BYTE) begin
      if (rx_phase == PH_IDLE && !rx_esc) return;
      await_result(1'b1, 8'h00, judge_frame());
      clear_frame_state(PH_IDLE);
      return;
    end
    // overlong frame
    if (rx_count >= MAX_FRAME - 2) begin
      await_result(1'b1, 8'h00, RESP_REJ);
      clear_frame_state(PH_HUNT);
      return;
    end
    rx_count++;
    // unstuffing
    if (rx_esc) begin
      rx_esc = 1'b0;
      b      = raw ^ ESC_XOR;
    end else if (raw == ESC_BYTE) begin
      rx_esc = 1'b1;
      return;
    end else begin
      b = raw;
    end
    case (rx_phase)
      PH_IDLE: begin
        rx_addr  = b;
        rx_phase = PH_ADDR;
      end
      PH_ADDR: begin
        rx_ctrl  = b;
        rx_phase = PH_CTRL;
      end
      PH_CTRL: rx_phase = (b == (rx_addr ^ rx_ctrl)) ? PH_DATA : PH_BAD;
      default: begin
        // the previous byte turns out not to be the check byte
        if (rx_held_v) begin
          rx_xor ^= rx_held;
          await_result(1'b0, rx_held, RESP_NONE);
        end
        rx_held   = b;
        rx_held_v = 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // line byte driver with random idle bursts
  always @(posedge clk) begin : line_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
      clear_frame_state(PH_HUNT);
      rx_exp_seq   = 1'b0;
      rx_link_open = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_line_byte(in_rx_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (line_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!tail_quiet && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          in_rx_byte <= line_bytes.pop_front();
        end
      end
    end
  end

  // result sink: random stall bursts and the occasional long hold-off
  always @(posedge clk) begin : result_sink
    if (!rst_n) begin
      out_ready <= 1'b1;
      ready_hold = 0;
    end else begin
      if (ready_hold == 0 && long_holds_done < long_holds_asked) begin
        long_holds_done++;
        ready_hold = 300;
      end else if (ready_hold == 0 && !tail_quiet && $urandom_range(0, 15) == 0) begin
        ready_hold = $urandom_range(1, 12);
      end
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_monitor
    rx_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with nothing awaited");
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("out_kind", want.kind, out_kind);
        check_field("out_payload_byte", want.payload, out_payload_byte);
        check_field("out_response", want.resp, out_response);
        check_field("out_ack_seq", want.ack_seq, out_ack_seq);
        check_field("out_frame_last", want.last, out_frame_last);
      end
    end
  end

  task automatic queue_line(logic [7:0] b);
    line_bytes.push_back(b);
    bytes_queued++;
  endtask

  // stuff flag and escape, and now and then escape an ordinary byte too
  task automatic queue_stuffed(logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE ||
        ((b ^ ESC_XOR) != FLAG_BYTE && $urandom_range(0, 15) == 0)) begin
      queue_line(ESC_BYTE);
      queue_line(b ^ ESC_XOR);
    end else begin
      queue_line(b);
    end
  endtask

  // byte values biased towards the flag and escape codes
  function automatic logic [7:0] pick_line_value();
    case ($urandom_range(0, 7))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(logic [7:0] addr, logic [7:0] ctrl, int n_data, bit with_check,
                            bit bad_header = 1'b0, bit bad_check = 1'b0, bit dangle = 1'b0);
    logic [7:0] sum;
    logic [7:0] d;
    sum = 8'h00;
    queue_line(FLAG_BYTE);
    queue_stuffed(addr);
    queue_stuffed(ctrl);
    queue_stuffed(addr ^ ctrl ^ (bad_header ? 8'($urandom_range(1, 255)) : 8'h00));
    repeat (n_data) begin
      d = pick_line_value();
      sum ^= d;
      queue_stuffed(d);
    end
    if (with_check) queue_stuffed(sum ^ (bad_check ? 8'($urandom_range(1, 255)) : 8'h00));
    if (dangle) queue_line(ESC_BYTE);
    queue_line(FLAG_BYTE);
  endtask

  // mostly well-formed information frames, with commands, faults and noise
  task automatic send_random_frame();
    int n;
    n = $urandom_range(0, 10);
    case ($urandom_range(0, 19))
      0, 1: begin
        send_frame(link_cfg.addr_to, link_cfg.ctrl_set, 0, 1'b0);
        gen_seq = 1'b0;
      end
      2: send_frame(link_cfg.addr_to, link_cfg.ctrl_disc, 0, 1'b0);
      3: send_frame(link_cfg.addr_from, link_cfg.ctrl_ua, 0, 1'b0);
      4: send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n,
                    $urandom_range(0, 1));
      5: begin
        // cut off inside the header, maybe on an escape
        queue_line(FLAG_BYTE);
        repeat ($urandom_range(0, 2)) queue_stuffed(pick_line_value());
        if ($urandom_range(0, 1)) queue_line(ESC_BYTE);
        queue_line(FLAG_BYTE);
      end
      6: repeat ($urandom_range(1, 8)) queue_line(pick_line_value());
      7: send_frame(link_cfg.addr_to, gen_seq ? link_cfg.ctrl_i0 : link_cfg.ctrl_i1, n, 1'b1);
      8: send_frame(link_cfg.addr_to, gen_seq ? link_cfg.ctrl_i1 : link_cfg.ctrl_i0, n,
                    $urandom_range(0, 1), $urandom_range(0, 3) == 0, $urandom_range(0, 1),
                    $urandom_range(0, 3) == 0);
      default: begin
        send_frame(link_cfg.addr_to, gen_seq ? link_cfg.ctrl_i1 : link_cfg.ctrl_i0, n, 1'b1);
        gen_seq = ~gen_seq;
      end
    endcase
  endtask

  // sender pause until every owed result has arrived
  task automatic wait_drained();
    do @(posedge clk); while (bytes_taken != bytes_queued || awaited_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_traffic(int n_bytes);
    int stop_at;
    stop_at = bytes_queued + n_bytes;
    send_frame(link_cfg.addr_to, link_cfg.ctrl_set, 0, 1'b0);
    gen_seq = 1'b0;
    while (bytes_queued < stop_at) send_random_frame();
    wait_drained();
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ADDR_TO:   link_cfg.addr_to   = value;
      CFG_ADDR_FROM: link_cfg.addr_from = value;
      CFG_CTRL_SET:  link_cfg.ctrl_set  = value;
      CFG_CTRL_DISC: link_cfg.ctrl_disc = value;
      CFG_CTRL_UA:   link_cfg.ctrl_ua   = value;
      CFG_CTRL_I0:   link_cfg.ctrl_i0   = value;
      CFG_CTRL_I1:   link_cfg.ctrl_i1   = value;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [7:0] addr_to, logic [7:0] addr_from, logic [7:0] c_set,
                             logic [7:0] c_disc, logic [7:0] c_ua, logic [7:0] c_i0,
                             logic [7:0] c_i1);
    write_register(CFG_ADDR_TO, addr_to);
    write_register(CFG_ADDR_FROM, addr_from);
    write_register(CFG_CTRL_SET, c_set);
    write_register(CFG_CTRL_DISC, c_disc);
    write_register(CFG_CTRL_UA, c_ua);
    write_register(CFG_CTRL_I0, c_i0);
    write_register(CFG_CTRL_I1, c_i1);
  endtask

  // stimulus sequence
  initial begin : stimulus
    logic [7:0] opening_bytes [24] = '{
      FLAG_BYTE, FLAG_BYTE, 8'h03, 8'h03, 8'h00, FLAG_BYTE,
      8'h03, 8'h00, 8'h03, ESC_BYTE, 8'h5e, ESC_BYTE, 8'h5e, FLAG_BYTE,
      8'h03, FLAG_BYTE,
      8'h03, 8'h40, 8'h44, FLAG_BYTE,
      8'h01, 8'h07, 8'h06, FLAG_BYTE
    };
    logic [7:0] d;
    logic [7:0] big_sum;
    link_cfg = '{addr_to: 8'd3, addr_from: 8'd1, ctrl_set: 8'd3, ctrl_disc: 8'd11,
                 ctrl_ua: 8'd7, ctrl_i0: 8'd0, ctrl_i1: 8'd64};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // repeated flags, open, stuffed info frame, short frame, bad header, close
    foreach (opening_bytes[i]) queue_line(opening_bytes[i]);
    wait_drained();

    // settings after reset, with the sink holding off for a long stretch
    long_holds_asked++;
    run_traffic(200);

    // largest frames: one exactly at the length limit, one past it
    send_frame(link_cfg.addr_to, link_cfg.ctrl_set, 0, 1'b0);
    queue_line(FLAG_BYTE);
    queue_line(link_cfg.addr_to);
    queue_line(link_cfg.ctrl_i0);
    queue_line(link_cfg.addr_to ^ link_cfg.ctrl_i0);
    big_sum = 8'h00;
    repeat (MAX_FRAME - 6) begin
      d = 8'($urandom_range(0, 63));
      big_sum ^= d;
      queue_line(d);
    end
    queue_line(big_sum);
    queue_line(FLAG_BYTE);
    queue_line(FLAG_BYTE);
    repeat (MAX_FRAME - 1) queue_line(8'($urandom_range(0, 63)));
    queue_line(FLAG_BYTE);
    wait_drained();

    // random settings, then the extremes and the line codes themselves
    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    run_traffic(180);
    load_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    run_traffic(180);
    load_config(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    run_traffic(180);
    load_config(FLAG_BYTE, ESC_BYTE, ESC_BYTE, FLAG_BYTE, 8'h5d, 8'h5e, 8'h20);
    run_traffic(180);

    // back to the reset settings, no idling on either side
    load_config(8'd3, 8'd1, 8'd3, 8'd11, 8'd7, 8'd0, 8'd64);
    tail_quiet = 1'b1;
    run_traffic(180);

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
